// ===== src/ist_pkg.sv =====
// Shared constants, types and helpers for the integer set table.
package ist_pkg;

   localparam int DEPTH     = 32;
   localparam int VALUE_W   = 32;
   localparam int CAP_W     = 6;
   localparam int COUNT_W   = 6;
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W    = $clog2(DEPTH + 1);
   localparam int CMP_W     = (FILL_W > CAP_W) ? FILL_W : CAP_W;
   localparam int CMP_CNT_W = (CMP_W > COUNT_W) ? CMP_W : COUNT_W;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(20);

   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic               was_present;
      logic               stored;
      logic               rejected_full;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   // Low count bits of the fill level, zero-extended when the fill is narrower.
   function automatic logic [COUNT_W-1:0] count_bits(input logic [FILL_W-1:0] fill);
      logic [CMP_CNT_W-1:0] wide;
      wide = CMP_CNT_W'(fill);
      return wide[COUNT_W-1:0];
   endfunction

endpackage

// ===== src/integer_set_table.sv =====
// Top level of the integer set table: capacity register, entry memory and sequencer.
//
// Bounded set of signed 32-bit integers held in a RAM in insertion order. An item
// is taken when start is high and busy is low; its result beat appears on the rsp_
// ports for exactly one cycle with rsp_valid high, and must be taken then. Each item
// scans n held entries, n being the number read before a match or the end (0 to 32):
// the scan reads one RAM entry per cycle over the single read port, then the DECIDE
// state decides and writes back. The next item can be accepted in the cycle its
// predecessor's result is shown. The capacity register resets to 20; values above
// the table depth act as the depth.
module integer_set_table
   import ist_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_action,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   output logic                      rsp_was_present,
   output logic                      rsp_stored,
   output logic                      rsp_rejected_full,
   output logic [COUNT_W-1:0]        rsp_count,
   input  logic                      csr_wr_en,
   input  logic [CAP_W-1:0]          csr_wr_data
);

   logic [CAP_W-1:0]   capacity_ff;
   logic [VALUE_W-1:0] rd_data;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;
   rsp_type            rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   ist_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .req_value  ($unsigned(req_value)),
      .capacity   (capacity_ff),
      .busy       (busy),
      .rd_data    (rd_data),
      .rd_addr    (rd_addr),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_was_present   = rsp.was_present;
   assign rsp_stored        = rsp.stored;
   assign rsp_rejected_full = rsp.rejected_full;
   assign rsp_count         = rsp.count;

endmodule

// ===== src/ist_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ist_ctrl.sv =====
// Scan sequencer: reads entries one per cycle, decides, writes back and holds fill count.
module ist_ctrl
   import ist_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_action,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [CAP_W-1:0]   capacity,
   output logic               busy,
   input  logic [VALUE_W-1:0] rd_data,
   output logic [IDX_W-1:0]   rd_addr,
   output logic               wr_en,
   output logic [IDX_W-1:0]   wr_addr,
   output logic [VALUE_W-1:0] wr_data,
   output logic               rsp_valid,
   output rsp_type            rsp
);

   typedef enum logic [1:0] {IDLE, SCAN, DECIDE} state_type;

   state_type          state_ff;
   logic               action_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               hit_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic match;
   logic last;
   logic room;
   logic fresh;
   logic put;
   logic full;

   assign match = (rd_data == value_ff);
   assign last  = ((FILL_W'(idx_ff) + FILL_W'(1)) == fill_ff);
   assign room  = (fill_ff < FILL_W'(DEPTH)) && (CMP_W'(fill_ff) < CMP_W'(capacity));
   assign fresh = (action_ff == ACTION_ADD) && !hit_ff;
   assign put   = fresh && room;
   assign full  = fresh && !room;
   assign fill_in = put ? fill_ff + FILL_W'(1) : fill_ff;

   // Issue the next slot while the current one is compared.
   assign rd_addr = (state_ff == SCAN) ? idx_ff + IDX_W'(1) : '0;
   assign wr_en   = (state_ff == DECIDE) && put;
   assign wr_addr = fill_ff[IDX_W-1:0];
   assign wr_data = value_ff;
   assign busy    = (state_ff != IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  action_ff <= req_action;
                  value_ff  <= req_value;
                  idx_ff    <= '0;
                  hit_ff    <= 1'b0;
                  state_ff  <= (fill_ff == '0) ? DECIDE : SCAN;
               end
            end
            SCAN: begin
               if (match) begin
                  hit_ff   <= 1'b1;
                  state_ff <= DECIDE;
               end else if (last) begin
                  state_ff <= DECIDE;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            DECIDE: begin
               fill_ff              <= fill_in;
               rsp_ff.was_present   <= hit_ff;
               rsp_ff.stored        <= put;
               rsp_ff.rejected_full <= full;
               rsp_ff.count         <= count_bits(fill_in);
               rsp_valid_ff         <= 1'b1;
               state_ff             <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== bench/tb.sv =====
// Testbench for integer_set_table: directed and random add/query beats checked against a set tracker.
module tb;
   import ist_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;

   // Mirror of the set contents; predicts each result beat and checks it in order.
   class set_tracker;
      logic [VALUE_W-1:0] held[$];
      logic [CAP_W-1:0]   capacity;
      rsp_type            pending_results[$];
      int                 errors;

      function new();
         capacity = CAPACITY_RESET;
         errors = 0;
      endfunction

      function void take_item(logic act, logic [VALUE_W-1:0] val);
         rsp_type want;
         int      limit;
         want = '0;
         foreach (held[i])
            if (held[i] == val) want.was_present = 1'b1;
         limit = (capacity > DEPTH) ? DEPTH : int'(capacity);
         if (act == ACTION_ADD && !want.was_present) begin
            if (held.size() < limit) begin
               held.push_back(val);
               want.stored = 1'b1;
            end else begin
               want.rejected_full = 1'b1;
            end
         end
         want.count = COUNT_W'(held.size());
         pending_results.push_back(want);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_beat(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("was_present", want.was_present, got.was_present);
         compare_field("stored", want.stored, got.stored);
         compare_field("rejected_full", want.rejected_full, got.rejected_full);
         compare_field("count", want.count, got.count);
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_action;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_was_present;
   logic                      rsp_stored;
   logic                      rsp_rejected_full;
   logic [COUNT_W-1:0]        rsp_count;
   logic                      csr_wr_en;
   logic [CAP_W-1:0]          csr_wr_data;

   set_tracker tracker;
   int         sender_idle_pct;
   int         stall_cycles;

   integer_set_table DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_was_present   (rsp_was_present),
      .rsp_stored        (rsp_stored),
      .rsp_rejected_full (rsp_rejected_full),
      .rsp_count         (rsp_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check result beats, note accepted beats, and watch for a stall.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_valid)
            tracker.check_beat('{rsp_was_present, rsp_stored, rsp_rejected_full, rsp_count});
         if (start && !busy)
            tracker.take_item(req_action, req_value);
         if (rsp_valid || (start && !busy)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("integer_set_table verification failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic send_item(input logic act, input logic [VALUE_W-1:0] val);
      int gap;
      gap = 0;
      start <= 1'b1;
      req_action <= act;
      req_value <= val;
      do @(posedge clock); while (busy);
      while ($urandom_range(99) < sender_idle_pct && gap < 20) gap++;
      // Hold start high for back-to-back beats; drop it only for a gap.
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      start <= 1'b0;
      // Step past this edge first so a beat taken at it is already noted.
      do @(posedge clock); while (tracker.pending_results.size() != 0 || busy);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.capacity = cap;
   endtask

   // Favor held values and a small pool so hits and duplicate adds stay common.
   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 40 && tracker.held.size() > 0)
         return tracker.held[$urandom_range(tracker.held.size() - 1)];
      if (r < 70)
         return VALUE_W'($urandom_range(15)) - VALUE_W'(8);
      return $urandom;
   endfunction

   task automatic run_phase(input logic [CAP_W-1:0] cap, input int pct, input int beats);
      write_capacity(cap);
      sender_idle_pct = pct;
      repeat (beats) send_item(logic'($urandom_range(1)), pick_value());
   endtask

   initial begin
      tracker = new();
      sender_idle_pct = 36;
      reset <= 1'b1;
      start <= 1'b0;
      req_action <= ACTION_ADD;
      req_value <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty set under the reset capacity.
      send_item(ACTION_QUERY, 32'h0000_0000);
      // No room at all: a new value is turned away.
      write_capacity('0);
      send_item(ACTION_ADD, 32'h7FFF_FFFF);
      // Room for one: store, re-add, overflow, then queries.
      write_capacity(CAP_W'(1));
      send_item(ACTION_ADD, 32'h8000_0000);
      send_item(ACTION_ADD, 32'h8000_0000);
      send_item(ACTION_ADD, 32'hFFFF_FFFF);
      send_item(ACTION_QUERY, 32'hFFFF_FFFF);
      send_item(ACTION_QUERY, 32'h8000_0000);
      write_capacity(CAP_W'(4));
      send_item(ACTION_ADD, 32'h0000_0000);
      send_item(ACTION_ADD, 32'hFFFF_FFFF);
      send_item(ACTION_ADD, 32'h7FFF_FFFF);
      send_item(ACTION_ADD, 32'h0000_0001);
      send_item(ACTION_QUERY, 32'h7FFF_FFFF);
      // Capacity dropped below the count: held values still found, new ones refused.
      write_capacity(CAP_W'(2));
      send_item(ACTION_QUERY, 32'h0000_0000);
      send_item(ACTION_ADD, 32'h0000_0000);
      send_item(ACTION_ADD, 32'h0000_0005);
      send_item(ACTION_QUERY, 32'h5555_AAAA);

      run_phase(CAP_W'(12), 36, 300);
      run_phase(CAP_W'(32), 54, 550);
      run_phase(CAP_W'(63), 0, 550);

      start <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0)
         $display("integer_set_table verification clean");
      else
         $display("integer_set_table verification failed");
      $finish;
   end

endmodule
